>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the interval window splitter.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IWS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iws assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IWS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iws assertion failed");

`endif

>>> rtl/iws_pkg.sv
// Package of the interval window splitter: payload types, widths, register
// indices and controller states. Depends on nothing.
package iws_pkg;

  localparam int TIME_BITS  = 48;
  localparam int CFG_BITS   = 47;
  localparam int CFG_IDX_W  = 1;
  localparam int DIV_CNT_W  = $clog2(CFG_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPERIMENT_LENGTH = 1'b0,
    REG_WINDOW_LENGTH     = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic signed [TIME_BITS-1:0] interval_start;
    logic signed [TIME_BITS-1:0] interval_end;
  } in_item_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] window_index;
    logic [CFG_BITS-1:0] overlap_time;
    logic                last_piece;
    logic                truncated;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLIP,
    S_DIV,
    S_SETUP,
    S_PIECE,
    S_EMIT
  } state_t;

endpackage

>>> rtl/interval_window_splitter.sv
// Top level of the interval window splitter: clip, bit-serial divide, emit.
// Depends on iws_pkg and assert_macros.svh.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------
//  input    | start / busy       | in_data  (iws_pkg::in_item_t)
//  result   | out_strobe         | out_data (iws_pkg::out_item_t)
//  config   | cfg_we             | cfg_index, cfg_data
//
// One transaction passes through a clip state, the restoring divider (one quotient bit a
// cycle), a setup state and a piece state and an emit state per result piece; each piece
// appears in the cycle after its emit state.
// Disabled or empty intervals return to idle after the clip state.
// Synchronous active-low reset clears the controller, strobe and configuration registers.
// Results cannot be stalled; busy stays high until the last piece is emitted.
module interval_window_splitter #(
  parameter int MAX_PIECES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  iws_pkg::in_item_t             in_data,
  output logic                          out_strobe,
  output iws_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [iws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iws_pkg::CFG_BITS-1:0]  cfg_data
);
  import iws_pkg::*;
  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(MAX_PIECES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_PIECES - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(CFG_BITS - 1);

  state_t                 state_r, state_nxt;
  in_item_t               in_r;
  logic [CFG_BITS-1:0]    dur_r, win_r;
  logic [CFG_BITS-1:0]    cur_r, end_r, quo_r, rem_r, idx_r, top_r;
  logic [CFG_BITS:0]      wend_r;
  logic                   done_r;
  logic [DIV_CNT_W-1:0]   div_cnt_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   out_strobe_r;
  out_item_t              out_data_r;

  logic [CFG_BITS-1:0]    clip_start, clip_end;
  logic                   skip;
  logic [CFG_BITS:0]      trial;
  logic                   trial_ge;
  logic                   cut;
  logic                   accept;

  function automatic logic [CFG_BITS-1:0] clip_time(logic signed [TIME_BITS-1:0] v,
                                                     logic [CFG_BITS-1:0] lim);
    logic [CFG_BITS-1:0] mag;
    mag = v[CFG_BITS-1:0];
    if (v[TIME_BITS-1]) begin
      return '0;
    end
    return (mag < lim) ? mag : lim;
  endfunction

  assign clip_start = clip_time(in_r.interval_start, dur_r);
  assign clip_end   = clip_time(in_r.interval_end, dur_r);
  assign skip       = (dur_r == '0) || (win_r == '0) || (clip_start >= clip_end);
  assign trial      = {rem_r, quo_r[CFG_BITS-1]};
  assign trial_ge   = trial >= {1'b0, win_r};
  assign cut        = !done_r && (cnt_r == LAST_CNT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_CLIP;
      S_CLIP:  state_nxt = skip ? S_IDLE : S_DIV;
      S_DIV:   if (div_cnt_r == DIV_LAST) state_nxt = S_SETUP;
      S_SETUP: state_nxt = S_PIECE;
      S_PIECE: state_nxt = S_EMIT;
      S_EMIT:  state_nxt = (done_r || cut) ? S_IDLE : S_PIECE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    accept = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      dur_r        <= '0;
      win_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == S_EMIT);
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_EXPERIMENT_LENGTH: dur_r <= cfg_data;
          REG_WINDOW_LENGTH:     win_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    case (state_r)
      S_CLIP: begin
        cur_r     <= clip_start;
        end_r     <= clip_end;
        quo_r     <= clip_start;
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      S_DIV: begin
        rem_r     <= trial_ge ? CFG_BITS'(trial - {1'b0, win_r}) : trial[CFG_BITS-1:0];
        quo_r     <= {quo_r[CFG_BITS-2:0], trial_ge};
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      S_SETUP: begin
        idx_r  <= quo_r;
        wend_r <= {1'b0, cur_r} - {1'b0, rem_r} + {1'b0, win_r};
        cnt_r  <= '0;
      end
      S_PIECE: begin
        done_r <= {1'b0, end_r} <= wend_r;
        top_r  <= ({1'b0, end_r} <= wend_r) ? end_r : wend_r[CFG_BITS-1:0];
      end
      S_EMIT: begin
        out_data_r.window_index <= idx_r;
        out_data_r.overlap_time <= top_r - cur_r;
        out_data_r.last_piece   <= done_r || cut;
        out_data_r.truncated    <= cut;
        cur_r  <= top_r;
        wend_r <= wend_r + {1'b0, win_r};
        idx_r  <= idx_r + 1'b1;
        cnt_r  <= cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  `IWS_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `IWS_ASSERT_IMP(a_strobe_from_emit, clk, rst_n, out_strobe_r, $past(state_r) == S_EMIT)
  `IWS_ASSERT_IMP(a_overlap_nonzero, clk, rst_n, out_strobe_r, out_data_r.overlap_time != '0)
  `IWS_ASSERT_IMP(a_trunc_is_last, clk, rst_n, out_strobe_r && out_data_r.truncated,
                  out_data_r.last_piece)
  `IWS_ASSERT_IMP(a_piece_count, clk, rst_n, state_r == S_EMIT, cnt_r <= LAST_CNT)

endmodule

>>> test/testbench.sv
// Testbench of interval_window_splitter: directed and random intervals under several
// experiment and window lengths, checked per transaction against a predictor of the split.
// Depends on iws_pkg and the RTL of the block.
module testbench;
  import iws_pkg::*;

  localparam int MAX_PIECES = 64;
  localparam logic [CFG_BITS-1:0] CFG_MAX = '1;
  localparam logic signed [TIME_BITS-1:0] T_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};
  localparam logic signed [TIME_BITS-1:0] T_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_data = '0;
  logic                 out_strobe;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]  cfg_data = '0;

  logic [63:0]  span_us = '0;
  logic [63:0]  window_us = '0;
  out_item_t    pieces_q[$];
  int unsigned  errors = 0;
  int unsigned  burst_left = 0;

  always #5 clk = ~clk;

  interval_window_splitter #(.MAX_PIECES(MAX_PIECES)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic logic [63:0] clip_us(logic signed [TIME_BITS-1:0] t, logic [63:0] lim);
    logic [63:0] v;
    v = '0;
    v[TIME_BITS-1:0] = t;
    if (t[TIME_BITS-1]) return '0;
    return (v < lim) ? v : lim;
  endfunction

  function automatic void predict_pieces(in_item_t it);
    logic [63:0] cur, stop, idx, wbase, wlen, room, ovl;
    int n;
    out_item_t p;
    if (span_us == 0 || window_us == 0) return;
    cur = clip_us(it.interval_start, span_us);
    stop = clip_us(it.interval_end, span_us);
    n = 0;
    while (cur < stop && n < MAX_PIECES) begin
      idx = cur / window_us;
      wbase = idx * window_us;
      wlen = span_us - wbase;
      if (wlen > window_us) wlen = window_us;
      room = wlen - (cur - wbase);
      ovl = stop - cur;
      if (ovl > room) ovl = room;
      cur += ovl;
      p.window_index = idx[CFG_BITS-1:0];
      p.overlap_time = ovl[CFG_BITS-1:0];
      p.truncated = (cur < stop) && (n == MAX_PIECES - 1);
      p.last_piece = (cur >= stop) || p.truncated;
      pieces_q = {pieces_q, p};
      n++;
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pieces_q.size() == 0) begin
        $error("unexpected transaction: window_index %0d overlap_time %0d",
               out_data.window_index, out_data.overlap_time);
        errors++;
      end else begin
        want = pieces_q.pop_front();
        check_field("window_index", 64'(want.window_index), 64'(out_data.window_index));
        check_field("overlap_time", 64'(want.overlap_time), 64'(out_data.overlap_time));
        check_field("last_piece", 64'(want.last_piece), 64'(out_data.last_piece));
        check_field("truncated", 64'(want.truncated), 64'(out_data.truncated));
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_interval(input logic signed [TIME_BITS-1:0] t0,
                               input logic signed [TIME_BITS-1:0] t1);
    in_item_t it;
    it.interval_start = t0;
    it.interval_end = t1;
    in_data <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_pieces(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 180) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = $urandom_range(0, 7);
    end
  endtask

  // hold the sender until all expected transactions arrive and busy drops, or time out
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 1000 && (pieces_q.size() != 0 || busy); i++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pieces_q.size() != 0) begin
      $error("%0d expected transactions never arrived", pieces_q.size());
      errors++;
      pieces_q.delete();
    end
    burst_left = 0;
  endtask

  task automatic set_span(input logic [CFG_BITS-1:0] dur, input logic [CFG_BITS-1:0] win);
    cfg_we <= 1'b1;
    cfg_index <= REG_EXPERIMENT_LENGTH;
    cfg_data <= dur;
    @(posedge clk);
    span_us = 64'(dur);
    cfg_index <= REG_WINDOW_LENGTH;
    cfg_data <= win;
    @(posedge clk);
    window_us = 64'(win);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [TIME_BITS-1:0] pick_time(logic [63:0] dur);
    logic [63:0] r, v;
    r = rand64();
    case ($urandom_range(0, 7))
      0: v = r;
      1: v = 64'd0 - r[9:0] - 64'd1;
      default: v = r % (dur + (dur >> 2) + 64'd2);
    endcase
    return v[TIME_BITS-1:0];
  endfunction

  task automatic send_random();
    logic [63:0] t0, t1;
    t0 = pick_time(span_us);
    if ($urandom_range(0, 2) == 0) t1 = pick_time(span_us);
    else t1 = t0 + rand64() % (window_us * 6 + 64'd2);
    send_interval(t0[TIME_BITS-1:0], t1[TIME_BITS-1:0]);
  endtask

  task automatic test_clipping();
    set_span(1000, 100);
    send_interval(0, 1000);
    send_interval(-5, 250);
    send_interval(950, 5000);
    send_interval(300, 300);
    send_interval(500, 200);
    send_interval(-100, -1);
    send_interval(T_MIN, T_MAX);
    send_interval(150, 160);
    drain();
  endtask

  task automatic test_short_last_window();
    set_span(1050, 100);
    send_interval(1000, 1100);
    send_interval(990, 1050);
    drain();
  endtask

  task automatic test_piece_limit();
    set_span(CFG_MAX, 1);
    send_interval(0, 64);
    send_interval(0, 65);
    send_interval(10, 200);
    drain();
  endtask

  task automatic test_extremes();
    set_span(CFG_MAX, CFG_MAX);
    send_interval(T_MIN, T_MAX);
    send_interval(0, T_MAX);
    drain();
  endtask

  task automatic test_disabled();
    set_span(0, 100);
    send_interval(0, 10);
    send_interval(T_MIN, T_MAX);
    send_interval(5, 500);
    drain();
    set_span(500, 0);
    send_interval(0, 10);
    send_interval(T_MIN, T_MAX);
    send_interval(5, 500);
    drain();
  endtask

  task automatic test_random_spans();
    logic [63:0] r1, r2;
    for (int ph = 0; ph < 6; ph++) begin
      r1 = rand64();
      r2 = rand64();
      case (ph)
        0: set_span(1000, 100);
        1: set_span(CFG_BITS'(r1 % 100000 + 1), CFG_BITS'(r2 % 5000 + 1));
        2: set_span(CFG_MAX, r2[CFG_BITS-1:0] | 1);
        3: set_span(r1[CFG_BITS-1:0] | 1, 1);
        4: set_span(CFG_BITS'(r1 % 64 + 1), CFG_BITS'(r2 % 8 + 1));
        default: set_span(r1[CFG_BITS-1:0] | 1, r2[CFG_BITS-1:0] | 1);
      endcase
      repeat (12) send_random();
      drain();
    end
  endtask

  task automatic test_back_to_back();
    set_span(2000, 250);
    burst_left = 20;
    repeat (20) send_random();
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_clipping();
    test_short_last_window();
    test_piece_limit();
    test_extremes();
    test_disabled();
    test_random_spans();
    test_back_to_back();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/iws_pkg.sv
rtl/interval_window_splitter.sv
test/testbench.sv
